// ----- rtl/arc_pkg.sv -----
// Shared types and constants for the ARP resolver cache.
`timescale 1ns / 1ps
package arc_pkg;

  // Request commands
  localparam logic [1:0] CMD_PKT    = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_MISS  = 2'd1;
  localparam logic [1:0] KIND_OWN   = 2'd2;
  localparam logic [1:0] KIND_REPLY = 2'd3;

  // Outgoing frame opcodes
  localparam logic [1:0] TX_NONE    = 2'd0;
  localparam logic [1:0] TX_REQUEST = 2'd1;
  localparam logic [1:0] TX_REPLY   = 2'd2;

  // ARP header values
  localparam logic [15:0] HW_ETHER     = 16'h0001;
  localparam logic [15:0] PROTO_IPV4   = 16'h0800;
  localparam logic [15:0] ARP_OP_REQ   = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY = 16'h0002;

  // Configuration register indexes
  localparam logic [1:0] REG_MY_IP  = 2'd0;
  localparam logic [1:0] REG_MY_MAC = 2'd1;
  localparam logic [1:0] REG_EXPIRY = 2'd2;

  localparam logic [31:0] EXPIRY_RESET = 32'd60;
  localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } cache_entry_t;

  typedef struct packed {
    logic       lat_en;
    logic       now_inc;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_en;
    logic       mem_we;
    logic       ins;
    logic       out_load;
    logic [1:0] kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       pkt_ok;
    logic       tip_mine;
    logic       q_mine;
    logic       op_req;
    logic       match;
    logic       idx_last;
    logic       live;
    logic       out_free;
  } dp_status_t;

endpackage

// ----- rtl/arc_ctrl.sv -----
// Sequencer for the ARP resolver cache: decode, table scan, update, result.
`timescale 1ns / 1ps
module arc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  arc_pkg::dp_status_t   st,
  output arc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_CMP,
    ST_FINISH,
    ST_RESULT
  } state_t;

  state_t     state_r, state_nxt;
  logic       found_r, found_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.lat_en = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (st.cmd)
          arc_pkg::CMD_TICK: begin
            cmd.now_inc = 1'b1;
            state_nxt   = ST_IDLE;
          end
          arc_pkg::CMD_LOOKUP: begin
            if (st.q_mine) begin
              kind_nxt  = arc_pkg::KIND_OWN;
              state_nxt = ST_RESULT;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_READ;
            end
          end
          arc_pkg::CMD_PKT: begin
            if (st.pkt_ok) begin
              cmd.idx_clr = 1'b1;
              state_nxt   = ST_READ;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (st.match) begin
          found_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else if (st.idx_last) begin
          found_nxt = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_FINISH: begin
        if (st.cmd == arc_pkg::CMD_PKT) begin
          cmd.mem_we = found_r || st.tip_mine;
          cmd.ins    = !found_r && st.tip_mine;
          if (st.tip_mine && st.op_req) begin
            kind_nxt  = arc_pkg::KIND_REPLY;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          kind_nxt  = (found_r && st.live) ? arc_pkg::KIND_HIT : arc_pkg::KIND_MISS;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
      kind_r  <= arc_pkg::KIND_HIT;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      kind_r  <= kind_nxt;
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_DECODE))
    else $error("accepted request did not move to decode");

  a_insert_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !found_r)
    else $error("insert issued for a sender already in the table");

  a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (state_r == ST_IDLE))
    else $error("sequencer not idle after result load");

  a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && !st.match && !st.idx_last) |=> (state_r == ST_READ))
    else $error("table scan stopped early");

endmodule

// ----- rtl/arc_datapath.sv -----
// Datapath: config registers, request latch, cache table, tick clock, result register.
`timescale 1ns / 1ps
module arc_datapath #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_wdata,
  input  logic [1:0]          in_cmd,
  input  logic [15:0]         in_hw_type,
  input  logic [15:0]         in_proto_type,
  input  logic [15:0]         in_opcode,
  input  logic [31:0]         in_src_ip,
  input  logic [47:0]         in_sender_mac,
  input  logic [31:0]         in_dst_ip,
  input  logic [31:0]         in_query_ip,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [47:0]         out_found_mac,
  output logic [1:0]          out_tx_opcode,
  output logic [47:0]         out_tx_dest_mac,
  output logic [31:0]         out_tx_target_ip,
  output logic [47:0]         out_tx_target_mac,
  input  arc_pkg::ctrl_cmd_t  cmd,
  output arc_pkg::dp_status_t st
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

  logic [31:0] my_ip_r;
  logic [47:0] my_mac_r;
  logic [31:0] expiry_r;
  logic [31:0] now_r;

  logic [1:0]  lat_cmd_r;
  logic [15:0] lat_hw_r, lat_proto_r, lat_op_r;
  logic [31:0] lat_sip_r, lat_tip_r, lat_query_r;
  logic [47:0] lat_smac_r;

  logic [IDX_W-1:0]         idx_r, ptr_r, wr_addr;
  logic [CACHE_ENTRIES-1:0] vld_r;
  arc_pkg::cache_entry_t    mem [CACHE_ENTRIES];
  arc_pkg::cache_entry_t    rd_entry_r, wr_entry;
  logic                     rd_vld_r;
  logic [31:0]              key, age;

  logic        out_valid_r;
  logic [1:0]  out_kind_r, out_op_r;
  logic [47:0] out_mac_r, out_dmac_r, out_tmac_r;
  logic [31:0] out_tip_r;

  // Configuration and tick clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_ip_r  <= '0;
      my_mac_r <= '0;
      expiry_r <= arc_pkg::EXPIRY_RESET;
      now_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          arc_pkg::REG_MY_IP:  my_ip_r  <= cfg_wdata[31:0];
          arc_pkg::REG_MY_MAC: my_mac_r <= cfg_wdata;
          arc_pkg::REG_EXPIRY: expiry_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (cmd.now_inc) now_r <= now_r + 32'd1;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.lat_en) begin
      lat_cmd_r   <= in_cmd;
      lat_hw_r    <= in_hw_type;
      lat_proto_r <= in_proto_type;
      lat_op_r    <= in_opcode;
      lat_sip_r   <= in_src_ip;
      lat_smac_r  <= in_sender_mac;
      lat_tip_r   <= in_dst_ip;
      lat_query_r <= in_query_ip;
    end
  end

  // Scan index, replacement pointer and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ptr_r <= '0;
      vld_r <= '0;
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + IDX_W'(1);
      if (cmd.ins) begin
        vld_r[ptr_r] <= 1'b1;
        ptr_r        <= (ptr_r == IDX_LAST) ? '0 : ptr_r + IDX_W'(1);
      end
    end
  end

  assign wr_addr = cmd.ins ? ptr_r : idx_r;
  assign wr_entry = '{ip: lat_sip_r, mac: lat_smac_r, stamp: now_r};

  // Cache table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[wr_addr] <= wr_entry;
    if (cmd.rd_en) begin
      rd_entry_r <= mem[idx_r];
      rd_vld_r   <= vld_r[idx_r];
    end
  end

  assign key = (lat_cmd_r == arc_pkg::CMD_LOOKUP) ? lat_query_r : lat_sip_r;
  assign age = now_r - rd_entry_r.stamp;

  always_comb begin
    st.cmd      = lat_cmd_r;
    st.pkt_ok   = (lat_hw_r == arc_pkg::HW_ETHER) && (lat_proto_r == arc_pkg::PROTO_IPV4);
    st.tip_mine = (lat_tip_r == my_ip_r);
    st.q_mine   = (lat_query_r == my_ip_r);
    st.op_req   = (lat_op_r == arc_pkg::ARP_OP_REQ);
    st.match    = rd_vld_r && (rd_entry_r.ip == key);
    st.idx_last = (idx_r == IDX_LAST);
    st.live     = (age <= expiry_r);
    st.out_free = !out_valid_r || out_ready;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.kind;
      out_mac_r  <= '0;
      out_op_r   <= arc_pkg::TX_NONE;
      out_dmac_r <= '0;
      out_tip_r  <= '0;
      out_tmac_r <= '0;
      case (cmd.kind)
        arc_pkg::KIND_HIT: out_mac_r <= rd_entry_r.mac;
        arc_pkg::KIND_OWN: out_mac_r <= my_mac_r;
        arc_pkg::KIND_MISS: begin
          out_op_r   <= arc_pkg::TX_REQUEST;
          out_dmac_r <= arc_pkg::BCAST_MAC;
          out_tip_r  <= lat_query_r;
        end
        arc_pkg::KIND_REPLY: begin
          out_op_r   <= arc_pkg::TX_REPLY;
          out_dmac_r <= lat_smac_r;
          out_tip_r  <= lat_sip_r;
          out_tmac_r <= lat_smac_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_found_mac     = out_mac_r;
  assign out_tx_opcode     = out_op_r;
  assign out_tx_dest_mac   = out_dmac_r;
  assign out_tx_target_ip  = out_tip_r;
  assign out_tx_target_mac = out_tmac_r;

endmodule

// ----- rtl/arp_resolver_cache_core.sv -----
// Top level of the ARP resolver cache: sequencer plus datapath.
`timescale 1ns / 1ps
// How to use this block:
// - Input channel (in_*): one request per valid/ready handshake. in_cmd selects a
//   received ARP packet, an address lookup or a time tick; unused fields are ignored.
// - Result channel (out_*): zero or one result per request, valid/ready. A lookup
//   always answers (hit, miss asking for a broadcast request, or own address); a
//   packet answers only with a reply to send when it is a request for our IP.
// - Configuration (cfg_*): write my_ip, my_mac or expiry_ticks while idle; writes
//   take effect at the next clock edge.
// - Timing: in_ready is high only while the sequencer is idle, so requests are
//   handled one at a time. A tick, a packet that is not Ethernet/IPv4 or an
//   unknown command returns to idle from the decode state. A lookup of our own IP
//   goes straight from decode to the result state. Otherwise the table is scanned
//   through its single read port, a read and a compare per entry, stopping at the
//   first match, with at most CACHE_ENTRIES entries examined; a finish state then
//   updates the table for a packet or picks hit or miss for a lookup.
// - Reset (rst_n, synchronous): clear all valid bits, the tick clock, the
//   replacement pointer, my_ip, my_mac and the state; no clearing sweep is needed.
// - Stall: a result waits in the output register; if it is still held when the
//   next result is ready, the sequencer holds until out_ready frees the register.
module arp_resolver_cache_core #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [15:0] in_opcode,
  input  logic [31:0] in_src_ip,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_dst_ip,
  input  logic [31:0] in_query_ip,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_found_mac,
  output logic [1:0]  out_tx_opcode,
  output logic [47:0] out_tx_dest_mac,
  output logic [31:0] out_tx_target_ip,
  output logic [47:0] out_tx_target_mac
);

  // Commands from the sequencer and status back from the datapath
  arc_pkg::ctrl_cmd_t  ctrl_cmd;
  arc_pkg::dp_status_t dp_st;

  arc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (dp_st),
    .cmd      (ctrl_cmd)
  );

  // Table, registers and result register; the table size sets the scan length
  arc_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_hw_type        (in_hw_type),
    .in_proto_type     (in_proto_type),
    .in_opcode         (in_opcode),
    .in_src_ip         (in_src_ip),
    .in_sender_mac     (in_sender_mac),
    .in_dst_ip         (in_dst_ip),
    .in_query_ip       (in_query_ip),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_found_mac     (out_found_mac),
    .out_tx_opcode     (out_tx_opcode),
    .out_tx_dest_mac   (out_tx_dest_mac),
    .out_tx_target_ip  (out_tx_target_ip),
    .out_tx_target_mac (out_tx_target_mac),
    .cmd               (ctrl_cmd),
    .st                (dp_st)
  );

endmodule
